// ===== sv/assert_macros.svh =====
// Assertion macros shared by the longest-run binner RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LROB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lrob assertion failed");

// Check a property on every clock edge, reset included.
`define LROB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("lrob assertion failed");

`endif

// ===== sv/lrob_pkg.sv =====
// Shared types, constants and decode helpers for the longest-run binner.
// No dependencies; used by lrob_core and longest_run_of_ones_binner.
`timescale 1ns / 1ps
`default_nettype none

package lrob_pkg;

  localparam int RUN_W   = 14;
  localparam int BIN_W   = 3;
  localparam int CNT_W   = 32;
  localparam int BIN_SLOTS = 7;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Register map (word index), and address width of the config port.
  localparam int ADDR_W = 3;
  localparam logic REG_BLOCK_MODE = 1'b0;

  typedef enum logic [1:0] {
    MODE_8   = 2'd0,
    MODE_128 = 2'd1,
    MODE_10K = 2'd2
  } block_mode_t;

  typedef struct packed {
    logic start_req;
    logic bit_in;
  } item_t;

  // First member lands in the highest bits, so block_longest sits at bit 0.
  typedef struct packed {
    logic [CNT_W-1:0] blocks_done;
    logic [CNT_W-1:0] bin_total;
    logic [BIN_W-1:0] bin_index;
    logic [RUN_W-1:0] block_longest;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [RUN_W-1:0] len;
    logic [RUN_W-1:0] lo;
    logic [RUN_W-1:0] hi;
  } mode_limits_t;

  // Unused code three decodes as the 10000-bit mode.
  function automatic mode_limits_t mode_limits(input logic [1:0] mode);
    mode_limits_t m;
    case (mode)
      MODE_8: begin
        m.len = RUN_W'(8);
        m.lo  = RUN_W'(1);
        m.hi  = RUN_W'(4);
      end
      MODE_128: begin
        m.len = RUN_W'(128);
        m.lo  = RUN_W'(4);
        m.hi  = RUN_W'(9);
      end
      default: begin
        m.len = RUN_W'(10000);
        m.lo  = RUN_W'(10);
        m.hi  = RUN_W'(16);
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lrob_core.sv =====
// Run tracking, block framing and bin counting for the longest-run binner.
// Depends on lrob_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lrob_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire lrob_pkg::item_t item,
  input  wire logic [1:0]      block_mode,
  output logic                 res_valid,
  output lrob_pkg::result_t    res
);

  logic [lrob_pkg::RUN_W-1:0] run_now, run_now_next;
  logic [lrob_pkg::RUN_W-1:0] run_best, run_best_next;
  logic [lrob_pkg::RUN_W-1:0] bit_offset, bit_offset_next;
  logic [lrob_pkg::CNT_W-1:0] bin_counts [lrob_pkg::BIN_SLOTS];
  logic [lrob_pkg::CNT_W-1:0] block_tally;

  lrob_pkg::mode_limits_t     lim;
  logic [lrob_pkg::RUN_W-1:0] run_base, best_base, off_base, run_inc, clamped, bin_wide;
  logic [lrob_pkg::BIN_W-1:0] bin;
  logic [lrob_pkg::CNT_W-1:0] cnt_sel, cnt_new, tally_base, tally_new;
  logic                       done;

  always_comb begin
    lim = lrob_pkg::mode_limits(block_mode);

    // A start request clears everything before this bit counts.
    run_base   = item.start_req ? '0 : run_now;
    best_base  = item.start_req ? '0 : run_best;
    off_base   = item.start_req ? '0 : bit_offset;
    tally_base = item.start_req ? '0 : block_tally;

    run_inc = (run_base == lrob_pkg::RUN_MAX) ? run_base : run_base + 1'b1;
    run_now_next  = item.bit_in ? run_inc : '0;
    run_best_next = (item.bit_in && (run_inc > best_base)) ? run_inc : best_base;

    bit_offset_next = off_base + 1'b1;
    done = (bit_offset_next >= lim.len);

    if (run_best_next < lim.lo) begin
      clamped = lim.lo;
    end else if (run_best_next > lim.hi) begin
      clamped = lim.hi;
    end else begin
      clamped = run_best_next;
    end
    bin_wide = clamped - lim.lo;
    bin      = bin_wide[lrob_pkg::BIN_W-1:0];

    cnt_sel   = item.start_req ? '0 : bin_counts[bin];
    cnt_new   = (cnt_sel == '1) ? cnt_sel : cnt_sel + 1'b1;
    tally_new = (tally_base == '1) ? tally_base : tally_base + 1'b1;

    res_valid         = done;
    res.block_longest = run_best_next;
    res.bin_index     = bin;
    res.bin_total     = cnt_new;
    res.blocks_done   = tally_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_now     <= '0;
      run_best    <= '0;
      bit_offset  <= '0;
      block_tally <= '0;
      for (int i = 0; i < lrob_pkg::BIN_SLOTS; i++) begin
        bin_counts[i] <= '0;
      end
    end else if (step) begin
      if (done) begin
        run_now     <= '0;
        run_best    <= '0;
        bit_offset  <= '0;
        block_tally <= tally_new;
      end else begin
        run_now     <= run_now_next;
        run_best    <= run_best_next;
        bit_offset  <= bit_offset_next;
        block_tally <= tally_base;
      end
      for (int i = 0; i < lrob_pkg::BIN_SLOTS; i++) begin
        if (done && (bin == lrob_pkg::BIN_W'(i))) begin
          bin_counts[i] <= cnt_new;
        end else if (item.start_req) begin
          bin_counts[i] <= '0;
        end
      end
    end
  end

  // Position never reaches the longest block length; a block end rewinds it.
  `LROB_ASSERT(a_offset_range, bit_offset < lrob_pkg::RUN_W'(10000))
  `LROB_ASSERT(a_best_covers_run, run_best >= run_now)
  `LROB_ASSERT(a_end_rewinds, (step && done) |=> (bit_offset == '0 && run_best == '0))

endmodule

`default_nettype wire

// ===== sv/longest_run_of_ones_binner.sv =====
// Top level of the longest-run-of-ones binner: stream ports, config port,
// input and result registers around lrob_core. Depends on lrob_pkg, lrob_core.
//
//  Channel | Dir | Payload                                          | Handshake
//  s_*     | in  | tdata[0] bit_in, tuser start_req                 | tvalid/tready
//  m_*     | out | block_longest, bin_index, bin_total, blocks_done | tvalid/tready
//  APB     | in  | block_mode at byte address 0                     | psel/penable
//
// One bit per cycle while the result stream is not stalled; a request sits in the
// input register while the run/bin logic works on it, and the result register
// loads from it when free, so m_tvalid rises as the result register loads.
// Results appear only on the last bit of a block (8, 128 or 10000 bits).
// rst is synchronous: clears both valid flags, all runs, counters and block_mode.
// A stalled result holds the result register; the input register takes one
// more request if it is empty, then s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module longest_run_of_ones_binner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [0] bit_in, [7:1] zero
  input  wire logic                          s_tuser,   // [0] start_req
  // Result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [13:0] block_longest, [16:14] bin_index, [48:17] bin_total,
  // [80:49] blocks_done, [87:81] zero
  output logic [lrob_pkg::TDATA_W-1:0]       m_tdata,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lrob_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [1:0]         block_mode;
  logic               in_valid;
  lrob_pkg::item_t    in_item;
  logic               out_free;
  logic               step;
  logic               res_valid;
  lrob_pkg::result_t  res;

  // Config register: word index is paddr[2], byte offset bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lrob_pkg::REG_BLOCK_MODE) ? {30'd0, block_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_mode <= lrob_pkg::MODE_8;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == lrob_pkg::REG_BLOCK_MODE)) begin
      block_mode <= pwdata[1:0];
    end
  end

  // Advance the held request whenever the result register can take its outcome.
  // Hold s_tready low in reset so no request is taken there.
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !rst && (!in_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.bit_in    <= s_tdata[0];
      in_item.start_req <= s_tuser;
    end
  end

  lrob_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_item),
    .block_mode (block_mode),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: load on a block end, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      m_tdata <= {(lrob_pkg::TDATA_W - lrob_pkg::RESULT_W)'(0), res};
    end
  end

endmodule

`default_nettype wire

// ===== verif/longest_run_of_ones_binner_tb.sv =====
// Self-checking testbench for longest_run_of_ones_binner: drives the bit stream and
// the APB mode register, predicts every block result and checks it on m_*.
// Depends on lrob_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module longest_run_of_ones_binner_tb;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int SETTLE_CYCLES    = 4;      // result path is two stages deep
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int STAGE_ITEMS      = 350;    // requests per idling stage
  localparam int MAX_PRINTED      = 40;
  localparam int SPARE_REG        = 1;      // word index past the register map
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Shadow of the block: runs, position, bin counters and block tally, plus the
  // queue of block results still owed by the design.
  class bin_tally_sb;
    logic [1:0]                 mode_reg;
    logic [lrob_pkg::RUN_W-1:0] cur_run;
    logic [lrob_pkg::RUN_W-1:0] best_run;
    logic [lrob_pkg::RUN_W-1:0] bit_pos;
    logic [lrob_pkg::CNT_W-1:0] bin_count [lrob_pkg::BIN_SLOTS];
    logic [lrob_pkg::CNT_W-1:0] block_count;
    lrob_pkg::result_t          expected_bins [$];
    int                         errors;

    function new();
      mode_reg = lrob_pkg::MODE_8;
      errors   = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      cur_run     = '0;
      best_run    = '0;
      bit_pos     = '0;
      block_count = '0;
      foreach (bin_count[i]) bin_count[i] = '0;
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == int'(lrob_pkg::REG_BLOCK_MODE)) mode_reg = value[1:0];
    endfunction

    // Advance the shadow by one accepted request; queue a result at block end.
    function void take_bit(logic b, logic start);
      logic [lrob_pkg::RUN_W-1:0] blk_len, lo, hi, clamped;
      logic [lrob_pkg::BIN_W-1:0] idx;
      lrob_pkg::result_t          r;
      if (start) clear_counts();
      case (mode_reg)
        lrob_pkg::MODE_8: begin
          blk_len = lrob_pkg::RUN_W'(8);
          lo      = lrob_pkg::RUN_W'(1);
          hi      = lrob_pkg::RUN_W'(4);
        end
        lrob_pkg::MODE_128: begin
          blk_len = lrob_pkg::RUN_W'(128);
          lo      = lrob_pkg::RUN_W'(4);
          hi      = lrob_pkg::RUN_W'(9);
        end
        default: begin
          blk_len = lrob_pkg::RUN_W'(10000);
          lo      = lrob_pkg::RUN_W'(10);
          hi      = lrob_pkg::RUN_W'(16);
        end
      endcase
      if (b) begin
        if (cur_run != lrob_pkg::RUN_MAX) cur_run = cur_run + 1'b1;
        if (cur_run > best_run) best_run = cur_run;
      end else begin
        cur_run = '0;
      end
      bit_pos = bit_pos + 1'b1;
      if (bit_pos < blk_len) return;
      clamped = (best_run < lo) ? lo : (best_run > hi) ? hi : best_run;
      idx = lrob_pkg::BIN_W'(clamped - lo);
      if (bin_count[idx] != '1) bin_count[idx] = bin_count[idx] + 1'b1;
      if (block_count != '1) block_count = block_count + 1'b1;
      r.block_longest = best_run;
      r.bin_index     = idx;
      r.bin_total     = bin_count[idx];
      r.blocks_done   = block_count;
      expected_bins.push_back(r);
      cur_run  = '0;
      best_run = '0;
      bit_pos  = '0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task check_result(lrob_pkg::result_t got);
      lrob_pkg::result_t want;
      if (expected_bins.size() == 0) begin
        report($sformatf("unexpected result, longest %0d bin %0d",
                         got.block_longest, got.bin_index));
        return;
      end
      want = expected_bins.pop_front();
      if (got.block_longest !== want.block_longest)
        report($sformatf("block_longest %0d, want %0d", got.block_longest,
                         want.block_longest));
      if (got.bin_index !== want.bin_index)
        report($sformatf("bin_index %0d, want %0d", got.bin_index, want.bin_index));
      if (got.bin_total !== want.bin_total)
        report($sformatf("bin_total %0d, want %0d", got.bin_total, want.bin_total));
      if (got.blocks_done !== want.blocks_done)
        report($sformatf("blocks_done %0d, want %0d", got.blocks_done,
                         want.blocks_done));
    endtask
  endclass

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata  = '0;    // [0] bit_in, [7:1] zero
  logic                           s_tuser  = 1'b0;  // [0] start_req
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [13:0] block_longest, [16:14] bin_index, [48:17] bin_total, [80:49] blocks_done
  logic [lrob_pkg::TDATA_W-1:0]   m_tdata;
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [lrob_pkg::ADDR_W-1:0]    paddr    = '0;
  logic [31:0]                    pwdata   = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  bin_tally_sb sb = new();
  int          items_sent  = 0;
  int          idle_stage  = 0;   // 0: sender busy, 1: receiver busy, 2: no idling
  int          cycle_count = 0;
  logic        hold_go     = 1'b0;
  logic        long_hold   = 1'b0;

  longest_run_of_ones_binner i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle rates per stage, in percent of cycles.
  function automatic int sender_idle_pct();
    return (idle_stage == 0) ? 6 : (idle_stage == 1) ? 69 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (idle_stage == 0) ? 69 : (idle_stage == 1) ? 6 : 0;
  endfunction

  // Drop m_tready at random; the long hold overrides everything.
  always @(negedge clk) begin
    m_tready <= !long_hold && ($urandom_range(99) >= receiver_idle_pct());
  end

  // Long receiver hold-off, counted here so the sender keeps offering requests
  // and the block backs up into s_tready.
  initial begin
    wait (hold_go);
    @(posedge clk) long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Sample both handshakes at the rising edge. Check results before noting the
  // request of the same edge: a result never depends on a request taken with it.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(lrob_pkg::result_t'(m_tdata[lrob_pkg::RESULT_W-1:0]));
      if (s_tvalid && s_tready) sb.take_bit(s_tdata[0], s_tuser);
    end
  end

  // Cap the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("longest_run_of_ones_binner verification failed");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_bit(input logic b, input logic start);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, b};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    idle_stage = (items_sent / STAGE_ITEMS) % 3;
  endtask

  // Send n bits of a pattern, lowest bit first; optionally start on the first.
  task automatic send_pattern(input logic [15:0] pattern, input int n,
                              input logic start_first);
    for (int i = 0; i < n; i++) send_bit(pattern[i], start_first && i == 0);
  endtask

  // Random stream: the density of ones (in eighths) is redrawn every chunk bits,
  // so runs range from none to long; start requests come at a rate in permille.
  task automatic stream_random(input int count, input int dens_lo, input int dens_hi,
                               input int chunk, input int start_permille);
    int dens;
    dens = dens_lo;
    for (int i = 0; i < count; i++) begin
      if (i % chunk == 0) dens = $urandom_range(dens_hi, dens_lo);
      send_bit($urandom_range(7) < dens, $urandom_range(999) < start_permille);
    end
  endtask

  // Drop s_tvalid, wait out every owed result, then let the pipeline settle
  // since the last request may have caused no result.
  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where pready is seen with penable.
  task automatic apb_write(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lrob_pkg::ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // A write past the register map must leave the mode alone.
    apb_write(SPARE_REG, 32'(lrob_pkg::MODE_10K));
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(lrob_pkg::MODE_8));

    // Directed: all ones clamps to the top bin, all zeros to the bottom one,
    // then a start request inside a block wipes runs and counters.
    send_pattern(16'h00FF, 8, 1'b1);
    send_pattern(16'h0000, 8, 1'b0);
    send_pattern(16'h0007, 3, 1'b0);
    send_pattern(16'h002D, 8, 1'b1);

    // 8-bit blocks with the long receiver hold-off at the start; leave a
    // partial block pending for the mode change.
    hold_go = 1'b1;
    stream_random(303, 0, 8, 8, 10);
    drain();

    // Grow to 128-bit blocks: the pending bits count toward the new block.
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(lrob_pkg::MODE_128));
    stream_random(400, 0, 8, 16, 1);
    drain();

    // Shrink back to 8 bits with the position already past the new length.
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(lrob_pkg::MODE_8));
    stream_random(20, 0, 8, 8, 0);
    drain();

    // 10000-bit blocks: a balanced stretch, then a run of ones, left pending.
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(lrob_pkg::MODE_10K));
    stream_random(100, 4, 4, 100, 0);
    stream_random(50, 8, 8, 50, 0);
    drain();

    // Code three decodes as 10000 bits; a fresh start then a long run of ones.
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(MODE_UNUSED));
    send_bit(1'b1, 1'b1);
    stream_random(59, 8, 8, 59, 0);
    drain();

    // Back to 8 bits: the long pending run ends a block at once, top bin.
    apb_write(int'(lrob_pkg::REG_BLOCK_MODE), 32'(lrob_pkg::MODE_8));
    stream_random(90, 0, 8, 8, 10);
    drain();

    if (sb.errors == 0) begin
      $display("longest_run_of_ones_binner verification clean");
    end else begin
      $display("longest_run_of_ones_binner verification failed");
    end
    $finish;
  end

endmodule
